// ===== sv/kbq_pkg.sv =====
// Shared types and constants for the keypad edge event queue.
// Depends on nothing; the top level refers to it by scoped names.
`timescale 1ns / 1ps

package kbq_pkg;

   // Key lines and key bit numbers
   localparam int KEY_W     = 10;
   localparam int KEY_BIT_W = 4;

   // Action map registers on the configuration port
   localparam int ACTION_W  = 6;
   localparam int MAP_REGS  = 6;
   localparam int CSR_IDX_W = 3;

   // Parameter defaults for the top level
   localparam int QUEUE_DEPTH_DEF  = 32;
   localparam int ACTION_COUNT_DEF = 6;

   // Stream widths; the data widths are padded to whole bytes
   localparam int REQ_USER_W = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - KEY_W - 1 - ACTION_W;

   typedef logic [KEY_W-1:0] key_mask_type;

   // Map register reset values: left, right, up, down, key A, start
   localparam key_mask_type MAP_RESET [MAP_REGS] = '{
      10'h020, 10'h010, 10'h040, 10'h080, 10'h001, 10'h008
   };

   // Request kinds carried in req_tuser
   typedef enum logic [REQ_USER_W-1:0] {
      REQ_POLL  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_FLUSH = 2'd2,
      REQ_QUERY = 2'd3
   } req_kind_type;

   // One result transaction
   typedef struct packed {
      logic                raw_key_valid;
      key_mask_type        raw_key_code;
      logic                action_held;
      logic [ACTION_W-1:0] action_states;
   } rsp_type;

endpackage

// ===== sv/keypad_edge_event_queue.sv =====
// Keypad controller with a ring of newly pressed key events.
// Depends on kbq_pkg for widths, request kinds, map resets and the result type.
`timescale 1ns / 1ps

// Usage
//   req_*: one request transaction each: poll key lines, pop the oldest key
//   event, flush the ring, or query one action's held bit (kind in req_tuser).
//   rsp_*: exactly one result transaction per request, in request order.
//   csr_*: write the six action key masks while the block is idle.
// Latency and throughput
//   A request is handled in one pass of logic in the cycle it is accepted; its
//   result is presented on rsp_* from the next cycle unless it goes to the skid
//   register. One request per cycle is sustained while rsp_tready stays high. A
//   poll writes its new key events that fit into the flop-based ring that same cycle.
// Reset
//   Synchronous reset empties the ring, clears the previous pressed set and
//   the held bits, restores the default key masks and drops pending results.
// Stall
//   While rsp_tready is low the result register holds; one more request is
//   taken into a skid register, after which req_tready drops until the
//   receiver takes a result.
module keypad_edge_event_queue #(
   parameter int QUEUE_DEPTH  = kbq_pkg::QUEUE_DEPTH_DEF,
   parameter int ACTION_COUNT = kbq_pkg::ACTION_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kbq_pkg::REQ_DATA_W-1:0]  req_tdata,  // key_lines[9:0], action_index[12:10]
   input  logic [kbq_pkg::REQ_USER_W-1:0]  req_tuser,  // req_type[1:0]
   // Result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kbq_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // raw_key_code[9:0],
                                                       // action_held[10],
                                                       // action_states[16:11]
   output logic                            rsp_tuser,  // raw_key_valid
   // Configuration writes
   input  logic                            csr_we,
   input  logic [kbq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [kbq_pkg::KEY_W-1:0]       csr_wdata
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SUM_W = ((PTR_W > kbq_pkg::KEY_BIT_W) ? PTR_W : kbq_pkg::KEY_BIT_W) + 1;
   localparam int KEY_W = kbq_pkg::KEY_W;

   // Request fields
   kbq_pkg::req_kind_type        req_kind;
   kbq_pkg::key_mask_type        key_lines;
   logic [2:0]                   action_index;
   logic                         accept;
   logic                         rsp_fire;

   // State
   kbq_pkg::key_mask_type        map_ff [kbq_pkg::MAP_REGS];
   logic [kbq_pkg::KEY_BIT_W-1:0] queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]             head_ff, head_in;
   logic [PTR_W-1:0]             tail_ff, tail_in;
   kbq_pkg::key_mask_type        prev_ff, prev_in;
   logic [kbq_pkg::ACTION_W-1:0] held_ff, held_in;

   // Result register and skid
   kbq_pkg::rsp_type             out_ff, skid_ff, rsp_in;
   logic                         out_valid_ff, skid_valid_ff;

   // Poll datapath
   kbq_pkg::key_mask_type        pressed;
   kbq_pkg::key_mask_type        fresh;
   kbq_pkg::key_mask_type        push;
   logic [SUM_W-1:0]             count;
   logic [SUM_W-1:0]             space;
   logic [SUM_W-1:0]             rank      [KEY_W];
   logic [SUM_W-1:0]             addr_sum  [KEY_W];
   logic [PTR_W-1:0]             addr      [KEY_W];
   logic [SUM_W-1:0]             head_sum;
   logic [SUM_W-1:0]             tail_sum;
   logic [kbq_pkg::KEY_BIT_W-1:0] pop_entry;
   logic                         ring_empty;

   assign req_kind     = kbq_pkg::req_kind_type'(req_tuser);
   assign key_lines    = req_tdata[KEY_W-1:0];
   assign action_index = req_tdata[KEY_W+2:KEY_W];

   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & req_tready;
   assign rsp_fire   = out_valid_ff & rsp_tready;

   // Ring occupancy and free slots
   always_comb begin
      if (head_ff >= tail_ff) begin
         count = SUM_W'(head_ff) - SUM_W'(tail_ff);
      end else begin
         count = SUM_W'(head_ff) + SUM_W'(QUEUE_DEPTH) - SUM_W'(tail_ff);
      end
      space      = SUM_W'(QUEUE_DEPTH - 1) - count;
      ring_empty = (head_ff == tail_ff);
      pop_entry  = queue_ff[tail_ff];
   end

   // Pressed set, new keys and their ring slots in ascending bit order
   always_comb begin
      pressed = ~key_lines;
      fresh   = pressed & ~prev_ff;
      for (int k = 0; k < KEY_W; k++) begin
         rank[k]     = SUM_W'($countones(fresh & KEY_W'((1 << k) - 1)));
         push[k]     = accept && (req_kind == kbq_pkg::REQ_POLL) && fresh[k] &&
                       (rank[k] < space);
         addr_sum[k] = SUM_W'(head_ff) + rank[k];
         if (addr_sum[k] >= SUM_W'(QUEUE_DEPTH)) begin
            addr[k] = PTR_W'(addr_sum[k] - SUM_W'(QUEUE_DEPTH));
         end else begin
            addr[k] = PTR_W'(addr_sum[k]);
         end
      end
   end

   // Next state and result for the accepted request
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      prev_in  = prev_ff;
      held_in  = held_ff;
      head_sum = SUM_W'(head_ff) + SUM_W'($countones(push));
      tail_sum = SUM_W'(tail_ff) + SUM_W'(1);
      rsp_in   = '0;

      unique case (req_kind)
         kbq_pkg::REQ_POLL: begin
            for (int a = 0; a < kbq_pkg::ACTION_W; a++) begin
               held_in[a] = (a < ACTION_COUNT) && (|(pressed & map_ff[a]));
            end
            prev_in = pressed;
            if (head_sum >= SUM_W'(QUEUE_DEPTH)) begin
               head_in = PTR_W'(head_sum - SUM_W'(QUEUE_DEPTH));
            end else begin
               head_in = PTR_W'(head_sum);
            end
         end
         kbq_pkg::REQ_POP: begin
            if (!ring_empty) begin
               rsp_in.raw_key_valid = 1'b1;
               if (pop_entry < kbq_pkg::KEY_BIT_W'(KEY_W)) begin
                  rsp_in.raw_key_code = KEY_W'(1) << pop_entry;
               end
               if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
                  tail_in = '0;
               end else begin
                  tail_in = PTR_W'(tail_sum);
               end
            end
         end
         kbq_pkg::REQ_FLUSH: begin
            tail_in = head_ff;
         end
         kbq_pkg::REQ_QUERY: begin
            if (action_index < 3'(ACTION_COUNT)) begin
               rsp_in.action_held = held_ff[action_index];
            end
         end
         default: begin
            tail_in = tail_ff;
         end
      endcase
      rsp_in.action_states = held_in;
   end

   // Advance control state on an accepted request; take map writes
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         prev_ff <= '0;
         held_ff <= '0;
         for (int i = 0; i < kbq_pkg::MAP_REGS; i++) begin
            map_ff[i] <= kbq_pkg::MAP_RESET[i];
         end
      end else begin
         if (accept) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
            prev_ff <= prev_in;
            held_ff <= held_in;
         end
         if (csr_we && (csr_index < kbq_pkg::CSR_IDX_W'(kbq_pkg::MAP_REGS))) begin
            map_ff[csr_index] <= csr_wdata;
         end
      end
   end

   // Write new key events into their ring slots
   always_ff @(posedge clock) begin
      for (int k = 0; k < KEY_W; k++) begin
         if (push[k]) begin
            queue_ff[addr[k]] <= kbq_pkg::KEY_BIT_W'(k);
         end
      end
   end

   // Result register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || rsp_fire) begin
            out_ff       <= rsp_in;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= rsp_in;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.raw_key_valid;
   assign rsp_tdata  = {{kbq_pkg::RSP_PAD_W{1'b0}}, out_ff.action_states,
                        out_ff.action_held, out_ff.raw_key_code};

   // A skid entry only exists behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without a pending result");

   // A flush leaves the ring empty
   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == kbq_pkg::REQ_FLUSH)) |=> (head_ff == tail_ff))
      else $error("ring not empty after flush");

   // A valid popped key is exactly one key line
   a_pop_onehot: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.raw_key_valid) |-> $onehot(out_ff.raw_key_code))
      else $error("popped key code is not one-hot");

   // A queried held bit agrees with the reported action states
   a_held_in_states: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.action_held) |-> (|out_ff.action_states))
      else $error("held bit set with no action held");

endmodule

// ===== bench/keypad_edge_event_queue_tb.sv =====
// Self-checking bench for the keypad edge event queue: directed and random
// requests against an in-bench predictor. Depends on kbq_pkg and the top level.
`timescale 1ns / 1ps

module keypad_edge_event_queue_tb;
   import kbq_pkg::*;

   localparam int RING_SLOTS  = QUEUE_DEPTH_DEF;
   localparam int ACTIONS     = ACTION_COUNT_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 6;
   localparam int RAND_ITEMS  = 185;

   typedef struct {
      req_kind_type          kind;
      key_mask_type          lines;
      logic [CSR_IDX_W-1:0]  idx;
   } key_req_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [REQ_USER_W-1:0]  req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [KEY_W-1:0]       csr_wdata;

   // Stimulus and expectations
   key_req_type  pending_reqs[$];
   rsp_type      expected_rsps[$];
   key_req_type  driven_req;
   logic         req_fired;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           mismatches;
   int           stall_cycles;
   int           rsps_checked;
   int           keys_popped;
   int           pushes_dropped;

   // Predictor state
   key_mask_type             key_map [MAP_REGS];
   logic [KEY_BIT_W-1:0]     ring_mem [RING_SLOTS];
   int                       ring_wr;
   int                       ring_rd;
   key_mask_type             prev_pressed;
   logic [ACTION_W-1:0]      held_bits;
   key_mask_type             gen_lines;

   keypad_edge_event_queue #(
      .QUEUE_DEPTH  (RING_SLOTS),
      .ACTION_COUNT (ACTIONS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // key_lines[9:0], action_index[12:10]
      .req_tuser  (req_tuser),   // req_type[1:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // raw_key_code[9:0], action_held[10], action_states[16:11]
      .rsp_tuser  (rsp_tuser),   // raw_key_valid
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Compute the result of one request and advance the predictor state
   function automatic rsp_type predict_keypad(key_req_type rq);
      rsp_type             r;
      key_mask_type        pressed;
      key_mask_type        fresh;
      logic [ACTION_W-1:0] held;
      int                  nxt;
      r = '0;
      case (rq.kind)
         REQ_POLL: begin
            pressed = ~rq.lines;
            fresh   = pressed & ~prev_pressed;
            held    = '0;
            for (int k = 0; k < ACTIONS && k < MAP_REGS; k++)
               if ((pressed & key_map[k]) != '0) held[k] = 1'b1;
            held_bits = held;
            // Push new keys low bit first; a full ring drops the push
            for (int k = 0; k < KEY_W; k++) begin
               if (fresh[k]) begin
                  nxt = (ring_wr + 1) % RING_SLOTS;
                  if (nxt != ring_rd) begin
                     ring_mem[ring_wr] = k[KEY_BIT_W-1:0];
                     ring_wr = nxt;
                  end else begin
                     pushes_dropped++;
                  end
               end
            end
            prev_pressed = pressed;
         end
         REQ_POP: begin
            if (ring_rd != ring_wr) begin
               r.raw_key_valid = 1'b1;
               if (ring_mem[ring_rd] < KEY_W)
                  r.raw_key_code = key_mask_type'(1) << ring_mem[ring_rd];
               ring_rd = (ring_rd + 1) % RING_SLOTS;
            end
         end
         REQ_FLUSH: ring_rd = ring_wr;
         default: begin
            if (rq.idx < ACTIONS) r.action_held = held_bits[rq.idx];
         end
      endcase
      r.action_states = held_bits;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %0s: got 'h%0h, expected 'h%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic add_req(req_kind_type kind, key_mask_type lines, int idx);
      key_req_type rq;
      rq.kind  = kind;
      rq.lines = lines;
      rq.idx   = idx[CSR_IDX_W-1:0];
      pending_reqs.push_back(rq);
   endtask

   // Write one map register at a falling edge; indexes above the map are ignored
   task automatic write_map(int idx, key_mask_type value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx[CSR_IDX_W-1:0];
      csr_wdata <= value;
      if (idx < MAP_REGS) key_map[idx] = value;
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every request is taken and every result has come back
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // Random requests: mostly realistic key activity with pops draining the ring,
   // some fill bursts that run into a full ring, and noise in unused fields
   task automatic fill_random(int count);
      int n;
      int pick;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            for (int b = 0; b < 6; b++)
               add_req(REQ_POLL, (b % 2) ? '0 : '1, $urandom_range(7));
            gen_lines = '0;
            n += 6;
         end else if (pick < 45) begin
            case ($urandom_range(9))
               0, 1, 2, 3: gen_lines = key_mask_type'($urandom);
               4, 5, 6, 7: gen_lines[$urandom_range(KEY_W-1)] ^= 1'b1;
               8:          gen_lines = '1;
               default:    gen_lines = '0;
            endcase
            add_req(REQ_POLL, gen_lines, $urandom_range(7));
            n++;
         end else if (pick < 78) begin
            add_req(REQ_POP, key_mask_type'($urandom), $urandom_range(7));
            n++;
         end else if (pick < 83) begin
            add_req(REQ_FLUSH, key_mask_type'($urandom), $urandom_range(7));
            n++;
         end else begin
            add_req(REQ_QUERY, key_mask_type'($urandom), $urandom_range(7));
            n++;
         end
      end
   endtask

   // Drive requests at the falling edge; hold an item until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (!req_tvalid || req_fired) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               driven_req = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= driven_req.kind;
               req_tdata  <= {{(REQ_DATA_W-KEY_W-CSR_IDX_W){1'b0}},
                              driven_req.idx, driven_req.lines};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Sample both channels at the rising edge: check results, then predict
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         req_fired    <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.raw_key_valid = rsp_tuser;
            got.raw_key_code  = rsp_tdata[KEY_W-1:0];
            got.action_held   = rsp_tdata[KEY_W];
            got.action_states = rsp_tdata[KEY_W+ACTION_W:KEY_W+1];
            if (expected_rsps.size() == 0) begin
               report_mismatch("result with nothing expected", int'(rsp_tdata), 0);
            end else begin
               want = expected_rsps.pop_front();
               if (got.raw_key_valid !== want.raw_key_valid)
                  report_mismatch("raw_key_valid", int'(got.raw_key_valid),
                                  int'(want.raw_key_valid));
               if (got.raw_key_code !== want.raw_key_code)
                  report_mismatch("raw_key_code", int'(got.raw_key_code),
                                  int'(want.raw_key_code));
               if (got.action_held !== want.action_held)
                  report_mismatch("action_held", int'(got.action_held),
                                  int'(want.action_held));
               if (got.action_states !== want.action_states)
                  report_mismatch("action_states", int'(got.action_states),
                                  int'(want.action_states));
               if (want.raw_key_valid) keys_popped++;
            end
            rsps_checked++;
         end
         if (req_tvalid && req_tready)
            expected_rsps.push_back(predict_keypad(driven_req));
         // Watchdog: end the run if no transaction moves for too long
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("[%0t] timeout: no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      mismatches     = 0;
      rsps_checked   = 0;
      keys_popped    = 0;
      pushes_dropped = 0;
      ring_wr        = 0;
      ring_rd        = 0;
      prev_pressed   = '0;
      held_bits      = '0;
      gen_lines      = '1;
      for (int k = 0; k < MAP_REGS; k++) key_map[k] = MAP_RESET[k];
      send_idle_pct  = 15;
      recv_idle_pct  = 58;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty ring, extremes of the key lines, full ring, flush
      add_req(REQ_QUERY, '0, 0);
      add_req(REQ_POP,   '1, 7);
      add_req(REQ_POLL,  '1, 0);
      add_req(REQ_POLL,  '0, 7);
      add_req(REQ_QUERY, '1, 5);
      add_req(REQ_QUERY, '0, 7);
      add_req(REQ_POLL,  '1, 3);
      add_req(REQ_POLL,  '0, 3);
      add_req(REQ_POLL,  '1, 0);
      add_req(REQ_POLL,  '0, 0);
      add_req(REQ_POLL,  '1, 0);
      add_req(REQ_POLL,  '0, 0);
      add_req(REQ_POP,   '0, 0);
      add_req(REQ_POP,   '0, 0);
      add_req(REQ_POLL,  '1, 0);
      add_req(REQ_POLL,  10'h3fe, 0);
      add_req(REQ_FLUSH, '0, 0);
      add_req(REQ_POP,   '0, 0);
      add_req(REQ_POLL,  10'h1ff, 6);
      add_req(REQ_POP,   '0, 0);
      add_req(REQ_POP,   '0, 0);
      add_req(REQ_QUERY, '0, 4);
      add_req(REQ_POLL,  10'h2aa, 1);
      add_req(REQ_QUERY, 10'h155, 2);
      add_req(REQ_FLUSH, '1, 7);
      fill_random(RAND_ITEMS);
      wait_idle();

      // Second setting: empty and full masks, random others, ignored indexes
      send_idle_pct = 58;
      recv_idle_pct = 15;
      write_map(0, '0);
      write_map(1, '1);
      for (int k = 2; k < MAP_REGS; k++) write_map(k, key_mask_type'($urandom));
      write_map(6, key_mask_type'($urandom));
      write_map(7, '1);
      end_writes();
      fill_random(RAND_ITEMS);
      wait_idle();

      // Third setting: swapped extremes and single-key masks
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_map(0, '1);
      write_map(1, '0);
      for (int k = 2; k < MAP_REGS; k++)
         write_map(k, key_mask_type'(1) << $urandom_range(KEY_W-1));
      end_writes();
      fill_random(RAND_ITEMS);
      wait_idle();

      if (expected_rsps.size() != 0)
         report_mismatch("results never received", expected_rsps.size(), 0);
      $display("Checked %0d results over three map settings and three idle profiles;",
               rsps_checked);
      $display("%0d pops returned keys, %0d key pushes hit a full ring.",
               keys_popped, pushes_dropped);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
